### rtl/core/gpg5x7_pkg.sv
package gpg5x7_pkg;

    localparam int DEFAULT_SCREEN_WIDTH  = 320;
    localparam int DEFAULT_SCREEN_HEIGHT = 240;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int CELL_COLS  = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] FG_RESET   = 16'hFFFF;
    localparam logic [15:0] BG_RESET   = 16'h0000;
    localparam logic        BOLD_RESET = 1'b1;

    typedef enum logic [1:0] {
        CFG_FOREGROUND = 2'd0,
        CFG_BACKGROUND = 2'd1,
        CFG_BOLD       = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

    typedef struct packed {
        glyph_t      glyph;
        logic [8:0]  origin_x;
        logic [7:0]  origin_y;
    } char_entry_t;

    typedef struct packed {
        logic [15:0] foreground_color;
        logic [15:0] background_color;
        logic        bold_enable;
    } pixel_cfg_t;

    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [5:0] idx;
        if (code >= "0" && code <= "9")
        begin
            idx = 6'(code - 8'h2F);
        end
        else
        begin
            unique case (code) inside
                "m":           idx = 6'd11;
                "V", "v":      idx = 6'd12;
                "u":           idx = 6'd13;
                "s":           idx = 6'd14;
                ".":           idx = 6'd15;
                ":":           idx = 6'd16;
                "=":           idx = 6'd17;
                "a":           idx = 6'd18;
                "f":           idx = 6'd19;
                "i":           idx = 6'd20;
                "K":           idx = 6'd21;
                "H":           idx = 6'd22;
                "z", "Z":      idx = 6'd23;
                "n", "N":      idx = 6'd24;
                "P":           idx = 6'd25;
                "X":           idx = 6'd26;
                "T":           idx = 6'd27;
                "R":           idx = 6'd28;
                "I":           idx = 6'd29;
                "G":           idx = 6'd30;
                "W":           idx = 6'd31;
                "A":           idx = 6'd32;
                "D":           idx = 6'd33;
                "%":           idx = 6'd34;
                "E":           idx = 6'd35;
                "L":           idx = 6'd36;
                "Q":           idx = 6'd37;
                "Y":           idx = 6'd38;
                "F":           idx = 6'd39;
                8'd169, "@":   idx = 6'd40;
                "C":           idx = 6'd41;
                "M":           idx = 6'd42;
                "O":           idx = 6'd43;
                "S":           idx = 6'd44;
                "c":           idx = 6'd45;
                "g":           idx = 6'd46;
                "h":           idx = 6'd47;
                "r":           idx = 6'd48;
                "t":           idx = 6'd49;
                "y":           idx = 6'd50;
                "o":           idx = 6'd51;
                "p":           idx = 6'd52;
                "-":           idx = 6'd53;
                "U":           idx = 6'd54;
                "+":           idx = 6'd55;
                default:       idx = 6'd0;
            endcase
        end
        return idx;
    endfunction

    // columns listed right to left: {col4, col3, col2, col1, col0}
    function automatic glyph_t font_rom(input logic [5:0] idx);
        glyph_t g;
        case (idx)
            6'd1:    g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
            6'd2:    g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
            6'd3:    g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
            6'd4:    g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
            6'd5:    g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
            6'd6:    g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
            6'd7:    g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
            6'd8:    g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
            6'd9:    g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            6'd10:   g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
            6'd11:   g = {7'h78, 7'h04, 7'h18, 7'h04, 7'h7C};
            6'd12:   g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            6'd13:   g = {7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C};
            6'd14:   g = {7'h48, 7'h54, 7'h54, 7'h54, 7'h24};
            6'd15:   g = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
            6'd16:   g = {7'h00, 7'h00, 7'h36, 7'h36, 7'h00};
            6'd17:   g = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
            6'd18:   g = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
            6'd19:   g = {7'h08, 7'h7E, 7'h09, 7'h01, 7'h02};
            6'd20:   g = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
            6'd21:   g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
            6'd22:   g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            6'd23:   g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
            6'd24:   g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
            6'd25:   g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
            6'd26:   g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
            6'd27:   g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            6'd28:   g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
            6'd29:   g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            6'd30:   g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
            6'd31:   g = {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
            6'd32:   g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
            6'd33:   g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
            6'd34:   g = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
            6'd35:   g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
            6'd36:   g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
            6'd37:   g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
            6'd38:   g = {7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
            6'd39:   g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
            6'd40:   g = {7'h3E, 7'h41, 7'h5D, 7'h55, 7'h3E};
            6'd41:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
            6'd42:   g = {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F};
            6'd43:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            6'd44:   g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            6'd45:   g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
            6'd46:   g = {7'h0C, 7'h52, 7'h52, 7'h52, 7'h3E};
            6'd47:   g = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
            6'd48:   g = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h00};
            6'd49:   g = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
            6'd50:   g = {7'h4C, 7'h50, 7'h50, 7'h50, 7'h3C};
            6'd51:   g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
            6'd52:   g = {7'h7C, 7'h24, 7'h24, 7'h24, 7'h18};
            6'd53:   g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
            6'd54:   g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
            6'd55:   g = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### rtl/core/gpg5x7_front.sv
module gpg5x7_front
(
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,
    input  logic                      queue_full,
    output logic                      push,
    output gpg5x7_pkg::char_entry_t   push_entry
);

    logic [7:0] char_code;

    assign char_code           = s_tdata[7:0];
    assign s_tready            = !queue_full;
    assign push                = s_tvalid && !queue_full;
    assign push_entry.glyph    = gpg5x7_pkg::font_rom(gpg5x7_pkg::glyph_index(char_code));
    assign push_entry.origin_x = s_tdata[16:8];
    assign push_entry.origin_y = s_tdata[24:17];

endmodule

### rtl/core/gpg5x7_queue.sv
module gpg5x7_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  gpg5x7_pkg::char_entry_t   push_entry,
    output logic                      full,
    input  logic                      pop,
    output logic                      head_valid,
    output gpg5x7_pkg::char_entry_t   head_entry
);

    localparam int PTR_W = gpg5x7_pkg::QUEUE_PTR_W;

    gpg5x7_pkg::char_entry_t entry_reg [gpg5x7_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full       = count_reg == (PTR_W+1)'(gpg5x7_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/gpg5x7_back.sv
module gpg5x7_back
#(
    parameter int SCREEN_WIDTH  = gpg5x7_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gpg5x7_pkg::DEFAULT_SCREEN_HEIGHT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gpg5x7_pkg::pixel_cfg_t    cfg,
    input  logic                      head_valid,
    input  gpg5x7_pkg::char_entry_t   head_entry,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata,
    output logic [1:0]                m_tuser,
    output logic                      m_tlast
);

    localparam logic [10:0] X_LIMIT      = 11'(SCREEN_WIDTH);
    localparam logic [10:0] X_BOLD_LIMIT = 11'(SCREEN_WIDTH - 1);
    localparam logic [10:0] Y_LIMIT      = 11'(SCREEN_HEIGHT);
    localparam logic [2:0]  LAST_COL     = 3'(gpg5x7_pkg::GLYPH_COLS - 1);
    localparam logic [2:0]  LAST_ROW     = 3'(gpg5x7_pkg::GLYPH_ROWS - 1);
    localparam logic [2:0]  GAP_COL0     = 3'(gpg5x7_pkg::GLYPH_COLS);
    localparam logic [2:0]  GAP_COL1     = 3'(gpg5x7_pkg::CELL_COLS - 1);

    typedef enum logic [1:0] {
        PH_GLYPH = 2'b01,
        PH_GAP   = 2'b10
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  col_reg;
    logic [2:0]  col_next;
    logic [2:0]  row_reg;
    logic [2:0]  row_next;

    logic        tvalid_reg;
    logic        tvalid_next;
    logic [8:0]  pixel_x_reg;
    logic [7:0]  pixel_y_reg;
    logic [15:0] pixel_color_reg;
    logic        also_right_reg;
    logic        on_screen_reg;
    logic        last_write_reg;

    logic        advance;
    logic        emit;
    logic        in_glyph;
    logic        last;
    logic        bit_set;
    logic [9:0]  px;
    logic [8:0]  py;
    logic [15:0] color;
    logic        right;
    logic        on;

    assign advance  = !tvalid_reg || m_tready;
    assign emit     = advance && head_valid;
    assign in_glyph = phase_reg == PH_GLYPH;
    assign last     = !in_glyph && col_reg == GAP_COL1 && row_reg == LAST_ROW;
    assign pop      = emit && last;

    always_comb
    begin
        bit_set = in_glyph && head_entry.glyph[col_reg][row_reg];
        px      = {1'b0, head_entry.origin_x} + 10'(col_reg);
        py      = {1'b0, head_entry.origin_y} + 9'(row_reg);
        on      = ({1'b0, px} < X_LIMIT) && ({2'b0, py} < Y_LIMIT);
        right   = bit_set && cfg.bold_enable && ({1'b0, px} < X_BOLD_LIMIT);
        color   = bit_set ? cfg.foreground_color : cfg.background_color;
    end

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (emit)
        begin
            unique case (phase_reg)
                PH_GLYPH:
                begin
                    if (row_reg == LAST_ROW)
                    begin
                        row_next = '0;
                        if (col_reg == LAST_COL)
                        begin
                            phase_next = PH_GAP;
                            col_next   = GAP_COL0;
                        end
                        else
                        begin
                            col_next = col_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                    end
                end
                PH_GAP:
                begin
                    if (col_reg == GAP_COL0)
                    begin
                        col_next = GAP_COL1;
                    end
                    else if (row_reg == LAST_ROW)
                    begin
                        phase_next = PH_GLYPH;
                        col_next   = '0;
                        row_next   = '0;
                    end
                    else
                    begin
                        col_next = GAP_COL0;
                        row_next = row_reg + 3'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_GLYPH;
                    col_next   = '0;
                    row_next   = '0;
                end
            endcase
        end
        tvalid_next = advance ? head_valid : tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_GLYPH;
            col_reg    <= '0;
            row_reg    <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg     <= px[8:0];
            pixel_y_reg     <= py[7:0];
            pixel_color_reg <= color;
            also_right_reg  <= right;
            on_screen_reg   <= on;
            last_write_reg  <= last;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = {7'b0, pixel_color_reg, pixel_y_reg, pixel_x_reg};
    assign m_tuser  = {on_screen_reg, also_right_reg};
    assign m_tlast  = last_write_reg;

endmodule

### rtl/core/glyph_pixel_generator_5x7.sv
// Draws one 5x7 font character per input beat as 49 pixel-write beats: the 35 glyph
// cells column by column (top to bottom), then the two blank gap columns row by row.
// One write leaves per cycle unless the output channel stalls it. A two-entry
// character queue sits between the decode front and the pixel sequencer, so new
// characters are taken while the previous one is still drawn and consecutive
// characters stream without a gap. Colors and bold are read as each write is
// formed; change them only while no character is in flight.
module glyph_pixel_generator_5x7
#(
    parameter int SCREEN_WIDTH  = gpg5x7_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gpg5x7_pkg::DEFAULT_SCREEN_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code, origin_x, origin_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic [1:0]  m_tuser,   // also_right, on_screen
    output logic        m_tlast    // last_write
);

    gpg5x7_pkg::pixel_cfg_t  cfg_reg;
    gpg5x7_pkg::pixel_cfg_t  cfg_next;
    gpg5x7_pkg::char_entry_t push_entry;
    gpg5x7_pkg::char_entry_t head_entry;
    logic                    push;
    logic                    pop;
    logic                    queue_full;
    logic                    head_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (gpg5x7_pkg::cfg_index_t'(cfg_index))
                gpg5x7_pkg::CFG_FOREGROUND: cfg_next.foreground_color = cfg_data;
                gpg5x7_pkg::CFG_BACKGROUND: cfg_next.background_color = cfg_data;
                gpg5x7_pkg::CFG_BOLD:       cfg_next.bold_enable      = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.foreground_color <= gpg5x7_pkg::FG_RESET;
            cfg_reg.background_color <= gpg5x7_pkg::BG_RESET;
            cfg_reg.bold_enable      <= gpg5x7_pkg::BOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gpg5x7_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    gpg5x7_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    gpg5x7_back
    #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
